// ===== hdl/paged_free_list_block_allocator_assert.svh =====
// Assertion macros used by the allocator back end (pfl_back).
// Both expect clk and rst in the scope where they are used.
`ifndef PAGED_FREE_LIST_BLOCK_ALLOCATOR_ASSERT_SVH
`define PAGED_FREE_LIST_BLOCK_ALLOCATOR_ASSERT_SVH

`define PFL_ASSERT_IMPL(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("allocator check failed");

`define PFL_ASSERT_NEXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("allocator check failed");

`endif

// ===== hdl/pfl_pkg.sv =====
`timescale 1ns / 1ps
package pfl_pkg;

  localparam int MAX_PAGES = 16;
  localparam int MAX_BLOCKS_PER_PAGE = 64;
  localparam int LINK_DEPTH = MAX_PAGES * MAX_BLOCKS_PER_PAGE;

  localparam int ADDR_W = $clog2(LINK_DEPTH);
  localparam int LINK_W = ADDR_W + 1;
  localparam int CNT_W = 11;
  localparam int PAGE_CNT_W = $clog2(MAX_PAGES + 1);
  localparam int PAGE_N_W = $clog2(MAX_BLOCKS_PER_PAGE + 1);
  localparam int IDX_W = (MAX_BLOCKS_PER_PAGE > 1) ? $clog2(MAX_BLOCKS_PER_PAGE) : 1;

  localparam int KIND_W = 2;
  localparam int BLOCK_W = 10;
  localparam int CFG_W = 7;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(LINK_DEPTH);
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FREE_ALL = 2'd2;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_NO_SPACE = 1'b1;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_FREE_ALL,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [BLOCK_W-1:0] block;
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_FILL,
    ST_GRANT
  } state_t;

endpackage

// ===== hdl/paged_free_list_block_allocator.sv =====
// A free, free-all or ignored request's result is registered in the cycle after it is
// accepted; an allocate that pops a listed block first reads the link memory in ST_POP.
// An allocate that opens a page writes its links in ST_FILL, one per cycle, then grants.
// One free, free-all or ignored request per cycle unless the output stalls; a pop blocks the next.
// Reset (synchronous, rst high) empties the queue, the free list and all counts and sets
// blocks_per_page to 64; the link memory is not cleared.
`timescale 1ns / 1ps
module paged_free_list_block_allocator
  import pfl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [CFG_W-1:0]      cfg_write_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [KIND_W-1:0]     kind,
  input  logic [BLOCK_W-1:0]    block,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [BLOCK_W-1:0]    granted_block,
  output logic                  status,
  output logic [CNT_W-1:0]      free_blocks,
  output logic [PAGE_CNT_W-1:0] pages_used,
  output logic [CNT_W-1:0]      total_blocks
);

  logic req_valid;
  req_t req;
  logic req_pop;

  pfl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .block     (block),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop)
  );

  pfl_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .req_valid      (req_valid),
    .req            (req),
    .req_pop        (req_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .granted_block  (granted_block),
    .status         (status),
    .free_blocks    (free_blocks),
    .pages_used     (pages_used),
    .total_blocks   (total_blocks)
  );

endmodule

// ===== hdl/pfl_front.sv =====
`timescale 1ns / 1ps
module pfl_front
  import pfl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [KIND_W-1:0]  kind,
  input  logic [BLOCK_W-1:0] block,
  output logic               req_valid,
  output req_t               req,
  input  logic               req_pop
);

  req_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  req_t              classified;

  always_comb begin
    classified.block = block;
    case (kind)
      KIND_ALLOC:    classified.op = OP_ALLOC;
      KIND_FREE:     classified.op = OP_FREE;
      KIND_FREE_ALL: classified.op = OP_FREE_ALL;
      default:       classified.op = OP_NOP;
    endcase
  end

  assign in_ready  = (count != QCNT_W'(QUEUE_DEPTH));
  assign push      = in_valid && in_ready;
  assign req_valid = (count != '0);
  assign req       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (req_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, req_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/pfl_back.sv =====
`timescale 1ns / 1ps
`include "paged_free_list_block_allocator_assert.svh"
module pfl_back
  import pfl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [CFG_W-1:0]      cfg_write_data,
  input  logic                  req_valid,
  input  req_t                  req,
  output logic                  req_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [BLOCK_W-1:0]    granted_block,
  output logic                  status,
  output logic [CNT_W-1:0]      free_blocks,
  output logic [PAGE_CNT_W-1:0] pages_used,
  output logic [CNT_W-1:0]      total_blocks
);

  logic [LINK_W-1:0] next_link [LINK_DEPTH];
  logic [LINK_W-1:0] rd_data;

  state_t                state;
  state_t                state_next;
  logic [CFG_W-1:0]      blocks_per_page;
  logic [LINK_W-1:0]     free_head;
  logic [LINK_W-1:0]     free_head_next;
  logic [PAGE_CNT_W-1:0] page_count;
  logic [PAGE_CNT_W-1:0] page_count_next;
  logic [CNT_W-1:0]      free_count;
  logic [CNT_W-1:0]      free_count_next;
  logic [CNT_W-1:0]      block_count;
  logic [CNT_W-1:0]      block_count_next;
  logic [PAGE_N_W-1:0]   page_n;
  logic [PAGE_N_W-1:0]   page_n_next;
  logic [IDX_W-1:0]      fill_idx;
  logic [IDX_W-1:0]      fill_idx_next;

  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_wa;
  logic [LINK_W-1:0]     mem_wd;
  logic                  mem_re;
  logic                  load_out;
  logic [BLOCK_W-1:0]    res_granted;
  logic                  res_status;

  logic                  out_free;
  logic [PAGE_N_W-1:0]   n_clamp;
  logic                  too_big;
  logic [ADDR_W-1:0]     fill_addr;
  logic                  fill_last;
  logic [CNT_W:0]        free_plus_n;

  assign out_free  = !out_valid || out_ready;
  assign too_big   = ({1'b0, block_count} + (CNT_W + 1)'(n_clamp)) > (CNT_W + 1)'(LINK_DEPTH);
  assign fill_addr = block_count[ADDR_W-1:0] + ADDR_W'(fill_idx);
  assign fill_last = (PAGE_N_W'(fill_idx) == page_n - 1'b1);
  assign free_plus_n = {1'b0, free_count} + (CNT_W + 1)'(page_n);

  always_comb begin
    if (blocks_per_page == '0) begin
      n_clamp = PAGE_N_W'(1);
    end else if (blocks_per_page > CFG_W'(MAX_BLOCKS_PER_PAGE)) begin
      n_clamp = PAGE_N_W'(MAX_BLOCKS_PER_PAGE);
    end else begin
      n_clamp = PAGE_N_W'(blocks_per_page);
    end
  end

  always_comb begin
    state_next       = state;
    free_head_next   = free_head;
    page_count_next  = page_count;
    free_count_next  = free_count;
    block_count_next = block_count;
    page_n_next      = page_n;
    fill_idx_next    = fill_idx;
    mem_we           = 1'b0;
    mem_wa           = fill_addr;
    mem_wd           = fill_last ? NULL_LINK : LINK_W'(fill_addr) + 1'b1;
    mem_re           = 1'b0;
    req_pop          = 1'b0;
    load_out         = 1'b0;
    res_granted      = '0;
    res_status       = STATUS_OK;
    case (state)
      ST_IDLE: begin
        if (req_valid && out_free) begin
          req_pop = 1'b1;
          case (req.op)
            OP_ALLOC: begin
              if (free_head != NULL_LINK) begin
                mem_re     = 1'b1;
                state_next = ST_POP;
              end else if (page_count >= PAGE_CNT_W'(MAX_PAGES) || too_big) begin
                load_out   = 1'b1;
                res_status = STATUS_NO_SPACE;
              end else begin
                page_n_next   = n_clamp;
                fill_idx_next = '0;
                state_next    = ST_FILL;
              end
            end
            OP_FREE: begin
              load_out = 1'b1;
              if (CNT_W'(req.block) < block_count) begin
                mem_we         = 1'b1;
                mem_wa         = ADDR_W'(req.block);
                mem_wd         = free_head;
                free_head_next = LINK_W'(req.block);
                if (free_count != COUNT_MAX) begin
                  free_count_next = free_count + 1'b1;
                end
              end
            end
            OP_FREE_ALL: begin
              load_out         = 1'b1;
              free_head_next   = NULL_LINK;
              page_count_next  = '0;
              free_count_next  = '0;
              block_count_next = '0;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      ST_POP: begin
        if (out_free) begin
          load_out       = 1'b1;
          res_granted    = BLOCK_W'(free_head);
          free_head_next = rd_data;
          if (free_count != '0) begin
            free_count_next = free_count - 1'b1;
          end
          state_next = ST_IDLE;
        end
      end
      ST_FILL: begin
        mem_we        = 1'b1;
        fill_idx_next = fill_idx + 1'b1;
        if (fill_last) begin
          state_next = ST_GRANT;
        end
      end
      ST_GRANT: begin
        if (out_free) begin
          load_out         = 1'b1;
          res_granted      = BLOCK_W'(block_count);
          free_head_next   = (page_n == PAGE_N_W'(1)) ? NULL_LINK :
                             LINK_W'(block_count) + 1'b1;
          page_count_next  = page_count + 1'b1;
          block_count_next = block_count + CNT_W'(page_n);
          free_count_next  = (free_plus_n > (CNT_W + 1)'(COUNT_MAX)) ?
                             COUNT_MAX - 1'b1 : CNT_W'(free_plus_n) - 1'b1;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_per_page <= CFG_RESET;
      free_head       <= NULL_LINK;
      page_count      <= '0;
      free_count      <= '0;
      block_count     <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        blocks_per_page <= cfg_write_data;
      end
      free_head   <= free_head_next;
      page_count  <= page_count_next;
      free_count  <= free_count_next;
      block_count <= block_count_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    page_n   <= page_n_next;
    fill_idx <= fill_idx_next;
    if (load_out) begin
      granted_block <= res_granted;
      status        <= res_status;
      free_blocks   <= free_count_next;
      pages_used    <= page_count_next;
      total_blocks  <= block_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      next_link[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data <= next_link[free_head[ADDR_W-1:0]];
    end
  end

  `PFL_ASSERT_IMPL(a_head_in_range, free_head != NULL_LINK, CNT_W'(free_head) < block_count)
  `PFL_ASSERT_IMPL(a_fill_has_room, state == ST_FILL, page_count < PAGE_CNT_W'(MAX_PAGES))
  `PFL_ASSERT_NEXT(a_pop_after_read, state == ST_IDLE && state_next == ST_POP,
                   free_head != NULL_LINK)

endmodule
